### rtl/core/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg: shared types and constants of the per-source packet rate blocker
// Field widths, request and result layouts, reason codes and register indexes.
// ----------------------------------------------------------------------------
package prb_pkg;

    localparam int SOURCE_ENTRIES = 64;
    localparam int GUARD_PORTS    = 4;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int LEN_W   = 16;
    localparam int TIME_W  = 64;
    localparam int COUNT_W = 32;
    localparam int TALLY_W = 64;

    localparam int IDX_W  = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(SOURCE_ENTRIES + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_MASK = 3'd5;

    localparam logic [COUNT_W-1:0] RESET_THRESHOLD = 32'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

    typedef enum logic [2:0] {
        REASON_NOT_TCP     = 3'd0,
        REASON_BLOCKED     = 3'd1,
        REASON_UNPROTECTED = 3'd2,
        REASON_OVER        = 3'd3,
        REASON_ALLOWED     = 3'd4
    } reason_t;

    // request layout, last field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [LEN_W-1:0]  frame_length;
        logic [PORT_W-1:0] dst_port;
        logic [PORT_W-1:0] src_port;
        logic [ADDR_W-1:0] dst_addr;
        logic [ADDR_W-1:0] src_addr;
    } pkt_t;

    typedef struct packed {
        logic [TALLY_W-1:0] denied_bytes;
        logic [TALLY_W-1:0] denied_packets;
        logic [TALLY_W-1:0] allowed_bytes;
        logic [TALLY_W-1:0] allowed_packets;
        logic [PORT_W-1:0]  event_dport;
        logic [PORT_W-1:0]  event_sport;
        logic [ADDR_W-1:0]  event_dst;
        logic [ADDR_W-1:0]  event_src;
        logic [TIME_W-1:0]  event_time;
    } res_t;

    typedef struct packed {
        logic    event_valid;
        reason_t reason;
        logic    verdict;
    } res_user_t;

    localparam int PKT_W      = $bits(pkt_t);
    localparam int RES_W      = $bits(res_t);
    localparam int RES_USER_W = $bits(res_user_t);
    localparam int EVENT_W    = TIME_W + 2 * ADDR_W + 2 * PORT_W;

    typedef struct packed {
        logic               blocked;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             hit;
        logic             room;
        logic [IDX_W-1:0] idx;
    } cam_result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] threshold;
        logic               port_protected;
    } cfg_view_t;

endpackage

### rtl/core/prb_ram.sv
// ----------------------------------------------------------------------------
// prb_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/prb_cfg_regs.sv
// ----------------------------------------------------------------------------
// prb_cfg_regs: configuration registers
// Threshold, protected port list and enable mask, plus the port match.
// ----------------------------------------------------------------------------
module prb_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [prb_pkg::PORT_W-1:0]        dst_port,
    output prb_pkg::cfg_view_t                view
);

    logic [prb_pkg::COUNT_W-1:0]     threshold_reg, threshold_next;
    logic [prb_pkg::PORT_W-1:0]      port_reg  [prb_pkg::GUARD_PORTS];
    logic [prb_pkg::PORT_W-1:0]      port_next [prb_pkg::GUARD_PORTS];
    logic [prb_pkg::GUARD_PORTS-1:0] mask_reg, mask_next;
    logic [prb_pkg::GUARD_PORTS-1:0] port_match;

    assign cfg_ready = 1'b1;

    always_comb begin
        threshold_next = threshold_reg;
        mask_next      = mask_reg;
        for (int i = 0; i < prb_pkg::GUARD_PORTS; i++) begin
            port_next[i] = port_reg[i];
        end
        if (cfg_valid) begin
            if (cfg_index == prb_pkg::CFG_THRESHOLD) begin
                threshold_next = cfg_data[prb_pkg::COUNT_W-1:0];
            end
            if (cfg_index == prb_pkg::CFG_PORT_MASK) begin
                mask_next = cfg_data[prb_pkg::GUARD_PORTS-1:0];
            end
            for (int i = 0; i < prb_pkg::GUARD_PORTS; i++) begin
                if (cfg_index == prb_pkg::CFG_PORT_A + prb_pkg::CFG_IDX_W'(i)) begin
                    port_next[i] = cfg_data[prb_pkg::PORT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= prb_pkg::RESET_THRESHOLD;
            mask_reg      <= '0;
            for (int i = 0; i < prb_pkg::GUARD_PORTS; i++) begin
                port_reg[i] <= '0;
            end
        end else begin
            threshold_reg <= threshold_next;
            mask_reg      <= mask_next;
            for (int i = 0; i < prb_pkg::GUARD_PORTS; i++) begin
                port_reg[i] <= port_next[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < prb_pkg::GUARD_PORTS; i++) begin
            port_match[i] = mask_reg[i] && (port_reg[i] == dst_port);
        end
    end

    assign view.threshold      = threshold_reg;
    assign view.port_protected = |port_match;

endmodule

### rtl/core/prb_src_cam.sv
// ----------------------------------------------------------------------------
// prb_src_cam: source address table
// Parallel compare of the stored source addresses, filled in entry order.
// ----------------------------------------------------------------------------
module prb_src_cam (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [prb_pkg::ADDR_W-1:0]    lookup_addr,
    input  logic                          alloc_en,
    output prb_pkg::cam_result_t          result
);

    logic [prb_pkg::ADDR_W-1:0]        addr_reg [prb_pkg::SOURCE_ENTRIES];
    logic [prb_pkg::FILL_W-1:0]        fill_reg, fill_next;
    logic [prb_pkg::SOURCE_ENTRIES-1:0] match;
    logic [prb_pkg::IDX_W-1:0]         match_idx;

    // entries below the fill count are live
    always_comb begin
        for (int i = 0; i < prb_pkg::SOURCE_ENTRIES; i++) begin
            match[i] = (prb_pkg::FILL_W'(i) < fill_reg) && (addr_reg[i] == lookup_addr);
        end
    end

    // at most one lane matches
    always_comb begin
        match_idx = '0;
        for (int i = 0; i < prb_pkg::SOURCE_ENTRIES; i++) begin
            match_idx = match_idx | (match[i] ? prb_pkg::IDX_W'(i) : '0);
        end
    end

    assign result.hit  = |match;
    assign result.room = (fill_reg != prb_pkg::FILL_W'(prb_pkg::SOURCE_ENTRIES));
    assign result.idx  = result.hit ? match_idx : fill_reg[prb_pkg::IDX_W-1:0];

    assign fill_next = alloc_en ? fill_reg + 1'b1 : fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (alloc_en) begin
            addr_reg[fill_reg[prb_pkg::IDX_W-1:0]] <= lookup_addr;
        end
    end

endmodule

### rtl/core/per_source_packet_rate_blocker.sv
// ----------------------------------------------------------------------------
// per_source_packet_rate_blocker: per-source packet rate blocker
// Drops packets from sources that exceed a packet count on protected ports.
// ----------------------------------------------------------------------------
// s_ channel takes one parsed header per request, m_ channel returns one
// verdict per request in the same order: verdict, reason and event flag on
// m_tuser, event fields and the four running tallies on m_tdata.
// cfg channel writes one register per request; it is always ready. The user
// must write it only while no request is in flight; the block does not enforce this.
// Three stages move in lockstep: input register (source table compare and
// new entry), count stage (count ram read, increment, threshold compare,
// write back), result register. One request per cycle is taken unless the
// receiver stalls, set by the single count ram port pair, with the last
// written entry forwarded to the next request.
// A stalled receiver (m_tvalid high, m_tready low) holds all three stages
// and drops s_tready in the same cycle.
// Reset clears the stage valids, the table fill count, the tallies and the
// registers to their defaults; the table needs no clearing pass, so a
// request can be taken as soon as reset is released.
// ----------------------------------------------------------------------------
module per_source_packet_rate_blocker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // src_addr, dst_addr, src_port, dst_port, frame_length, arrival_time
    input  logic [prb_pkg::PKT_W-1:0]         s_tdata,
    // is_tcp_ipv4
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // event_time, event_src, event_dst, event_sport, event_dport,
    // allowed_packets, allowed_bytes, denied_packets, denied_bytes
    output logic [prb_pkg::RES_W-1:0]         m_tdata,
    // verdict, reason, event_valid
    output logic [prb_pkg::RES_USER_W-1:0]    m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [prb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                 advance;
    prb_pkg::cfg_view_t   cfg_view;
    prb_pkg::cam_result_t cam_res;
    logic                 alloc;

    // input stage
    logic          a_valid_reg, a_valid_next;
    logic          a_tcp_reg, a_tcp_next;
    prb_pkg::pkt_t a_pkt_reg, a_pkt_next;

    // count stage
    logic                      b_valid_reg, b_valid_next;
    logic                      b_tcp_reg, b_tcp_next;
    prb_pkg::pkt_t             b_pkt_reg, b_pkt_next;
    logic                      b_hit_reg, b_hit_next;
    logic                      b_prot_reg, b_prot_next;
    logic                      b_alloc_reg, b_alloc_next;
    logic [prb_pkg::IDX_W-1:0] b_idx_reg, b_idx_next;
    logic                      b_fwd_reg, b_fwd_next;
    prb_pkg::entry_t           b_fwd_data_reg, b_fwd_data_next;

    logic [prb_pkg::ENTRY_W-1:0] ram_rdata;
    prb_pkg::entry_t             entry;
    prb_pkg::entry_t             wr_data;
    logic                        wr_need;
    logic                        wr_en;
    logic [prb_pkg::COUNT_W-1:0] count_inc;
    logic                        verdict;
    prb_pkg::reason_t            reason;
    logic                        event_hit;
    logic [prb_pkg::TALLY_W-1:0] len_ext;

    // tallies
    logic [prb_pkg::TALLY_W-1:0] allowed_pkts_reg, allowed_pkts_next;
    logic [prb_pkg::TALLY_W-1:0] allowed_bytes_reg, allowed_bytes_next;
    logic [prb_pkg::TALLY_W-1:0] denied_pkts_reg, denied_pkts_next;
    logic [prb_pkg::TALLY_W-1:0] denied_bytes_reg, denied_bytes_next;

    // result stage
    logic                       out_valid_reg, out_valid_next;
    prb_pkg::res_user_t         out_user_reg, out_user_next;
    logic [prb_pkg::EVENT_W-1:0] out_event_reg, out_event_next;

    prb_pkg::res_t res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance && aresetn;

    prb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dst_port  (a_pkt_reg.dst_port),
        .view      (cfg_view)
    );

    assign alloc = a_valid_reg && a_tcp_reg && !cam_res.hit && cfg_view.port_protected
                   && cam_res.room;

    prb_src_cam u_cam (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lookup_addr (a_pkt_reg.src_addr),
        .alloc_en    (advance && alloc),
        .result      (cam_res)
    );

    prb_ram #(
        .WIDTH (prb_pkg::ENTRY_W),
        .DEPTH (prb_pkg::SOURCE_ENTRIES)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (b_idx_reg),
        .wdata (wr_data),
        .re    (advance),
        .raddr (cam_res.idx),
        .rdata (ram_rdata)
    );

    // input stage
    always_comb begin
        a_valid_next = a_valid_reg;
        a_tcp_next   = a_tcp_reg;
        a_pkt_next   = a_pkt_reg;
        if (advance) begin
            a_valid_next = s_tvalid;
            a_tcp_next   = s_tuser[0];
            a_pkt_next   = prb_pkg::pkt_t'(s_tdata);
        end
    end

    // count stage capture, with forwarding of the entry written this cycle
    always_comb begin
        b_valid_next    = b_valid_reg;
        b_tcp_next      = b_tcp_reg;
        b_pkt_next      = b_pkt_reg;
        b_hit_next      = b_hit_reg;
        b_prot_next     = b_prot_reg;
        b_alloc_next    = b_alloc_reg;
        b_idx_next      = b_idx_reg;
        b_fwd_next      = b_fwd_reg;
        b_fwd_data_next = b_fwd_data_reg;
        if (advance) begin
            b_valid_next    = a_valid_reg;
            b_tcp_next      = a_tcp_reg;
            b_pkt_next      = a_pkt_reg;
            b_hit_next      = cam_res.hit;
            b_prot_next     = cfg_view.port_protected;
            b_alloc_next    = alloc;
            b_idx_next      = cam_res.idx;
            b_fwd_next      = wr_en && (b_idx_reg == cam_res.idx);
            b_fwd_data_next = wr_data;
        end
    end

    assign entry     = b_fwd_reg ? b_fwd_data_reg : prb_pkg::entry_t'(ram_rdata);
    assign count_inc = (entry.count == prb_pkg::COUNT_MAX) ? entry.count
                                                           : entry.count + 1'b1;

    always_comb begin
        verdict   = 1'b0;
        reason    = prb_pkg::REASON_ALLOWED;
        event_hit = 1'b0;
        wr_need   = 1'b0;
        wr_data   = entry;
        if (!b_tcp_reg) begin
            reason = prb_pkg::REASON_NOT_TCP;
        end else if (b_hit_reg && entry.blocked) begin
            verdict = 1'b1;
            reason  = prb_pkg::REASON_BLOCKED;
        end else if (!b_prot_reg) begin
            reason = prb_pkg::REASON_UNPROTECTED;
        end else if (b_hit_reg) begin
            wr_need       = 1'b1;
            wr_data.count = count_inc;
            if (count_inc > cfg_view.threshold) begin
                wr_data.blocked = 1'b1;
                verdict         = 1'b1;
                reason          = prb_pkg::REASON_OVER;
            end else begin
                event_hit = 1'b1;
            end
        end else begin
            event_hit = 1'b1;
            if (b_alloc_reg) begin
                wr_need         = 1'b1;
                wr_data.blocked = 1'b0;
                wr_data.count   = prb_pkg::COUNT_W'(1);
            end
        end
    end

    assign wr_en   = advance && b_valid_reg && wr_need;
    assign len_ext = prb_pkg::TALLY_W'(b_pkt_reg.frame_length);

    always_comb begin
        allowed_pkts_next  = allowed_pkts_reg;
        allowed_bytes_next = allowed_bytes_reg;
        denied_pkts_next   = denied_pkts_reg;
        denied_bytes_next  = denied_bytes_reg;
        if (advance && b_valid_reg) begin
            if (verdict) begin
                denied_pkts_next  = denied_pkts_reg + 1'b1;
                denied_bytes_next = denied_bytes_reg + len_ext;
            end else if (event_hit) begin
                allowed_pkts_next  = allowed_pkts_reg + 1'b1;
                allowed_bytes_next = allowed_bytes_reg + len_ext;
            end
        end
    end

    // result stage
    always_comb begin
        out_valid_next = out_valid_reg;
        out_user_next  = out_user_reg;
        out_event_next = out_event_reg;
        if (advance) begin
            out_valid_next            = b_valid_reg;
            out_user_next.verdict     = verdict;
            out_user_next.reason      = reason;
            out_user_next.event_valid = event_hit;
            out_event_next            = event_hit ? {b_pkt_reg.dst_port, b_pkt_reg.src_port,
                                                     b_pkt_reg.dst_addr, b_pkt_reg.src_addr,
                                                     b_pkt_reg.arrival_time} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg       <= 1'b0;
            b_valid_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            allowed_pkts_reg  <= '0;
            allowed_bytes_reg <= '0;
            denied_pkts_reg   <= '0;
            denied_bytes_reg  <= '0;
        end else begin
            a_valid_reg       <= a_valid_next;
            b_valid_reg       <= b_valid_next;
            out_valid_reg     <= out_valid_next;
            allowed_pkts_reg  <= allowed_pkts_next;
            allowed_bytes_reg <= allowed_bytes_next;
            denied_pkts_reg   <= denied_pkts_next;
            denied_bytes_reg  <= denied_bytes_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_tcp_reg      <= a_tcp_next;
        a_pkt_reg      <= a_pkt_next;
        b_tcp_reg      <= b_tcp_next;
        b_pkt_reg      <= b_pkt_next;
        b_hit_reg      <= b_hit_next;
        b_prot_reg     <= b_prot_next;
        b_alloc_reg    <= b_alloc_next;
        b_idx_reg      <= b_idx_next;
        b_fwd_reg      <= b_fwd_next;
        b_fwd_data_reg <= b_fwd_data_next;
        out_user_reg   <= out_user_next;
        out_event_reg  <= out_event_next;
    end

    // tallies change only when a new result is loaded
    assign res.denied_bytes    = denied_bytes_reg;
    assign res.denied_packets  = denied_pkts_reg;
    assign res.allowed_bytes   = allowed_bytes_reg;
    assign res.allowed_packets = allowed_pkts_reg;
    assign {res.event_dport, res.event_sport, res.event_dst, res.event_src,
            res.event_time} = out_event_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res;
    assign m_tuser  = out_user_reg;

endmodule

### rtl/core/prb_checker.sv
// ----------------------------------------------------------------------------
// prb_checker: port-level checks of the per-source packet rate blocker
// Result consistency and stall behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module prb_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [prb_pkg::RES_W-1:0]         m_tdata,
    input logic [prb_pkg::RES_USER_W-1:0]    m_tuser
);

    prb_pkg::res_user_t user;
    prb_pkg::res_t      res;

    assign user = prb_pkg::res_user_t'(m_tuser);
    assign res  = prb_pkg::res_t'(m_tdata);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_drop_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (user.verdict == (user.reason == prb_pkg::REASON_BLOCKED ||
                                       user.reason == prb_pkg::REASON_OVER)))
        else $error("verdict does not match reason");

    a_event_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (user.event_valid == (user.reason == prb_pkg::REASON_ALLOWED)))
        else $error("event flag does not match reason");

    a_event_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !user.event_valid |-> (res.event_time == '0 && res.event_src == '0 &&
            res.event_dst == '0 && res.event_sport == '0 && res.event_dport == '0))
        else $error("event fields set without an event");

endmodule

bind per_source_packet_rate_blocker prb_checker u_prb_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the per-source packet rate blocker
// Streams parsed headers through the block under several register settings
// and checks every verdict, event and tally against a per-source count
// predictor. The source table is taken through blocking, full-table and
// untracked sources, with source gaps and random or periodic sink stalls in most phases.
// ----------------------------------------------------------------------------
module tb;
    import prb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int POOL_SIZE = 40;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 115;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_SLOW} ready_mode_t;

    class verdict_scoreboard;
        logic [COUNT_W-1:0] threshold;
        logic [PORT_W-1:0]  guard_port [GUARD_PORTS];
        logic [3:0]         guard_mask;
        bit                 src_valid   [SOURCE_ENTRIES];
        logic [ADDR_W-1:0]  src_address [SOURCE_ENTRIES];
        logic [COUNT_W-1:0] src_count   [SOURCE_ENTRIES];
        bit                 src_blocked [SOURCE_ENTRIES];
        logic [TALLY_W-1:0] allow_pkts, allow_bytes, deny_pkts, deny_bytes;
        res_t               want_data [$];
        res_user_t          want_user [$];
        int                 errors;
        int                 results;
        int                 untracked;
        int                 reason_hits [5];

        function new();
            threshold  = RESET_THRESHOLD;
            guard_mask = '0;
            foreach (guard_port[i]) guard_port[i] = '0;
            foreach (src_valid[i]) begin
                src_valid[i]   = 1'b0;
                src_address[i] = '0;
                src_count[i]   = '0;
                src_blocked[i] = 1'b0;
            end
            allow_pkts  = '0;
            allow_bytes = '0;
            deny_pkts   = '0;
            deny_bytes  = '0;
            errors      = 0;
            results     = 0;
            untracked   = 0;
            foreach (reason_hits[i]) reason_hits[i] = 0;
        endfunction

        function int pending();
            return want_data.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_THRESHOLD) begin
                threshold = data;
            end else if (idx == CFG_PORT_MASK) begin
                guard_mask = data[3:0];
            end else if (idx >= CFG_PORT_A && idx < CFG_PORT_A + GUARD_PORTS) begin
                guard_port[idx - CFG_PORT_A] = data[PORT_W-1:0];
            end
        endfunction

        function void note_request(pkt_t hdr, bit tcp);
            res_t      d;
            res_user_t u;
            int        hit;
            int        room;
            bit        guarded;
            bit        emit;
            hit     = -1;
            room    = -1;
            guarded = 1'b0;
            emit    = 1'b0;
            u.verdict = 1'b0;
            u.reason  = REASON_ALLOWED;
            if (!tcp) begin
                u.reason = REASON_NOT_TCP;
            end else begin
                for (int i = 0; i < SOURCE_ENTRIES; i++) begin
                    if (hit < 0 && src_valid[i] && src_address[i] == hdr.src_addr) hit = i;
                    if (room < 0 && !src_valid[i]) room = i;
                end
                for (int i = 0; i < GUARD_PORTS; i++)
                    if (guard_mask[i] && guard_port[i] == hdr.dst_port) guarded = 1'b1;
                if (hit >= 0 && src_blocked[hit]) begin
                    u.verdict = 1'b1;
                    u.reason  = REASON_BLOCKED;
                end else if (!guarded) begin
                    u.reason = REASON_UNPROTECTED;
                end else if (hit >= 0) begin
                    if (src_count[hit] != COUNT_MAX) src_count[hit]++;
                    if (src_count[hit] > threshold) begin
                        src_blocked[hit] = 1'b1;
                        u.verdict = 1'b1;
                        u.reason  = REASON_OVER;
                    end else begin
                        emit = 1'b1;
                    end
                end else begin
                    if (room >= 0) begin
                        src_valid[room]   = 1'b1;
                        src_address[room] = hdr.src_addr;
                        src_count[room]   = 1;
                        src_blocked[room] = 1'b0;
                    end else begin
                        untracked++;
                    end
                    emit = 1'b1;
                end
            end
            if (u.verdict) begin
                deny_pkts  += 1;
                deny_bytes += hdr.frame_length;
            end else if (emit) begin
                allow_pkts  += 1;
                allow_bytes += hdr.frame_length;
            end
            u.event_valid     = emit;
            d.event_time      = emit ? hdr.arrival_time : '0;
            d.event_src       = emit ? hdr.src_addr : '0;
            d.event_dst       = emit ? hdr.dst_addr : '0;
            d.event_sport     = emit ? hdr.src_port : '0;
            d.event_dport     = emit ? hdr.dst_port : '0;
            d.allowed_packets = allow_pkts;
            d.allowed_bytes   = allow_bytes;
            d.denied_packets  = deny_pkts;
            d.denied_bytes    = deny_bytes;
            reason_hits[u.reason]++;
            want_data.push_back(d);
            want_user.push_back(u);
        endfunction

        function void compare_field(string label, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 40)
                    $display("%0t mismatch %s expected %0h actual %0h", $time, label, want, got);
            end
        endfunction

        function void check_result(res_t d, res_user_t u);
            res_t      wd;
            res_user_t wu;
            results++;
            if (want_data.size() == 0) begin
                errors++;
                $display("%0t result with no request waiting: tuser %0h", $time, u);
                return;
            end
            wd = want_data.pop_front();
            wu = want_user.pop_front();
            compare_field("verdict", wu.verdict, u.verdict);
            compare_field("reason", wu.reason, u.reason);
            compare_field("event_valid", wu.event_valid, u.event_valid);
            compare_field("event_time", wd.event_time, d.event_time);
            compare_field("event_src", wd.event_src, d.event_src);
            compare_field("event_dst", wd.event_dst, d.event_dst);
            compare_field("event_sport", wd.event_sport, d.event_sport);
            compare_field("event_dport", wd.event_dport, d.event_dport);
            compare_field("allowed_packets", wd.allowed_packets, d.allowed_packets);
            compare_field("allowed_bytes", wd.allowed_bytes, d.allowed_bytes);
            compare_field("denied_packets", wd.denied_packets, d.denied_packets);
            compare_field("denied_bytes", wd.denied_bytes, d.denied_bytes);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    pkt_t                  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    res_t                  m_tdata;
    res_user_t             m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    verdict_scoreboard sb = new();
    ready_mode_t       ready_mode = READY_ALWAYS;
    logic [7:0]        stall_phase = '0;
    logic [PORT_W-1:0] cur_port [GUARD_PORTS];
    logic [ADDR_W-1:0] src_pool [POOL_SIZE];
    int                burst_left = 0;
    bit                gaps_on = 1'b1;
    int                sent = 0;

    per_source_packet_rate_blocker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
            READY_PERIODIC: m_tready <= (stall_phase[2:0] < 3'd5);
            default:        m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (aresetn && s_tvalid && s_tready) sb.note_request(s_tdata, s_tuser[0]);
        if (aresetn && cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
    end

    task send_header(input bit tcp, input pkt_t hdr);
        int gap;
        begin
            if (gaps_on && burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 20);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            if (burst_left > 0) burst_left--;
            s_tvalid <= 1'b1;
            s_tdata  <= hdr;
            s_tuser  <= tcp;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sent++;
        end
    endtask

    task send_fields(input bit tcp, input logic [31:0] src, input logic [31:0] dst,
                     input logic [15:0] sport, input logic [15:0] dport,
                     input logic [15:0] len, input logic [63:0] stamp);
        pkt_t hdr;
        begin
            hdr.src_addr     = src;
            hdr.dst_addr     = dst;
            hdr.src_port     = sport;
            hdr.dst_port     = dport;
            hdr.frame_length = len;
            hdr.arrival_time = stamp;
            send_header(tcp, hdr);
        end
    endtask

    task wait_results_done();
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            @(posedge aclk);
            while (sb.pending() != 0) @(posedge aclk);
            repeat (4) @(posedge aclk);
        end
    endtask

    task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cfg_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // upper data bits are random to show that only the register width counts
    task apply_setting(input logic [31:0] limit_value, input logic [3:0] mask);
        logic [31:0] noise;
        begin
            write_register(CFG_THRESHOLD, limit_value);
            for (int i = 0; i < GUARD_PORTS; i++) begin
                noise = $urandom;
                write_register(CFG_PORT_A + CFG_IDX_W'(i), {noise[31:16], cur_port[i]});
            end
            noise = $urandom;
            write_register(CFG_PORT_MASK, {noise[31:4], mask});
        end
    endtask

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'd22;
            2: return 16'd80;
            3: return 16'd443;
            4: return 16'd8080;
            5: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pkt_t random_header(input int fresh_pct);
        pkt_t hdr;
        begin
            hdr.src_addr = ($urandom_range(0, 99) < fresh_pct) ? $urandom
                         : src_pool[$urandom_range(0, POOL_SIZE - 1)];
            hdr.dst_addr = $urandom;
            hdr.src_port = 16'($urandom);
            hdr.dst_port = ($urandom_range(0, 9) < 7) ? cur_port[$urandom_range(0, 3)]
                         : 16'($urandom);
            hdr.frame_length = 16'($urandom);
            hdr.arrival_time = {$urandom, $urandom};
            return hdr;
        end
    endfunction

    function automatic logic [31:0] phase_threshold(input int ph);
        case (ph)
            0: return 32'hFFFF_FFFF;
            1: return 32'd3;
            2: return RESET_THRESHOLD;
            3: return 32'd1;
            4: return 32'd2;
            5: return 32'd0;
            6: return 32'd5;
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    initial begin
        logic [3:0] mask;
        int         fresh;
        src_pool[0] = 32'h0;
        src_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) src_pool[i] = $urandom;
        foreach (cur_port[i]) cur_port[i] = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: nothing protected
        ready_mode = READY_RANDOM;
        send_fields(1'b0, '1, '1, '1, '1, '1, '1);
        send_fields(1'b0, '0, '0, '0, '0, '0, '0);
        send_fields(1'b1, '1, '1, '1, 16'd0, '1, '1);
        send_fields(1'b1, '0, '0, '0, 16'd80, '0, '0);
        wait_results_done();

        // port c disabled by the mask
        cur_port[0] = 16'd80;
        cur_port[1] = 16'd443;
        cur_port[2] = 16'd0;
        cur_port[3] = 16'hFFFF;
        apply_setting(32'd2, 4'b1011);
        write_register(CFG_SPARE, $urandom);
        send_fields(1'b1, 32'h0A00_0001, '1, '1, 16'd80, '1, '1);
        send_fields(1'b1, 32'h0A00_0001, 32'h1, 16'd1, 16'd443, 16'd64, 64'd2);
        send_fields(1'b1, 32'h0A00_0001, 32'h2, 16'd2, 16'hFFFF, 16'd1500, 64'd3);
        send_fields(1'b1, 32'h0A00_0001, 32'h3, 16'd3, 16'd80, 16'd60, 64'd4);
        send_fields(1'b1, 32'h0A00_0001, 32'h4, 16'd4, 16'd1234, 16'd60, 64'd5);
        send_fields(1'b0, 32'h0A00_0001, 32'h5, 16'd5, 16'd80, 16'd60, 64'd6);
        send_fields(1'b1, 32'h0, 32'h6, 16'd6, 16'd0, 16'd70, 64'd7);
        send_fields(1'b1, 32'h0, 32'h7, 16'd7, 16'd80, 16'd80, 64'd8);
        send_fields(1'b1, 32'hFFFF_FFFF, '0, '0, 16'd443, 16'd0, 64'd9);
        wait_results_done();

        // zero threshold: new source passes, its next packet is over
        apply_setting(32'd0, 4'b1111);
        send_fields(1'b1, 32'h0B00_0002, 32'h8, 16'd8, 16'd0, 16'd90, 64'd10);
        send_fields(1'b1, 32'h0B00_0002, 32'h9, 16'd9, 16'd80, 16'd91, 64'd11);
        send_fields(1'b1, 32'hFFFF_FFFF, 32'hA, 16'd10, 16'd443, 16'd92, 64'd12);
        send_fields(1'b1, 32'hFFFF_FFFF, 32'hB, 16'd11, 16'd22, 16'd93, 64'd13);
        wait_results_done();

        for (int ph = 0; ph < PHASES; ph++) begin
            foreach (cur_port[i]) cur_port[i] = pick_port();
            mask = (ph == 2) ? 4'h0 : (ph == 6) ? 4'hF : 4'($urandom_range(1, 15));
            apply_setting(phase_threshold(ph), mask);
            ready_mode = ready_mode_t'(ph % 4);
            gaps_on    = !(ph == 0 || ph == 5);
            // the table fills up during phase four
            fresh = (ph == 4) ? 60 : 10;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (ph == 3 && n == PHASE_LEN / 2) wait_results_done();
                send_header($urandom_range(0, 9) != 0, random_header(fresh));
            end
            wait_results_done();
        end

        repeat (8) @(posedge aclk);
        $display("sent %0d headers, checked %0d results, %0d sources passed untracked",
                 sent, sb.results, sb.untracked);
        $display("reasons: not tcp %0d, blocked %0d, unprotected %0d, over %0d, allowed %0d",
                 sb.reason_hits[REASON_NOT_TCP], sb.reason_hits[REASON_BLOCKED],
                 sb.reason_hits[REASON_UNPROTECTED], sb.reason_hits[REASON_OVER],
                 sb.reason_hits[REASON_ALLOWED]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### per_source_packet_rate_blocker.f
rtl/core/prb_pkg.sv
rtl/core/prb_ram.sv
rtl/core/prb_cfg_regs.sv
rtl/core/prb_src_cam.sv
rtl/core/per_source_packet_rate_blocker.sv
rtl/core/prb_checker.sv
tb/sv/tb.sv
